// ----- rtl/oflt_pkg.sv -----
// Shared types and constants for the face line triangulator.
package oflt_pkg;

  localparam int TriIndexBits = 24;
  localparam int IdxW         = 32;
  localparam int QAddrW       = 2;
  localparam int QDepth       = 1 << QAddrW;

  // Place of a finished vertex within its face.
  localparam logic [1:0] ORD_FIRST  = 2'd0;
  localparam logic [1:0] ORD_SECOND = 2'd1;
  localparam logic [1:0] ORD_LATER  = 2'd2;

  typedef struct packed {
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] tex;
    logic [IdxW-1:0] nrm;
    logic [1:0]      ord;
  } vtx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/oflt_front.sv -----
// Byte parser: classifies lines, accumulates decimal fields, emits finished vertices.
module oflt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take,
  input  logic [7:0]          byte_in,
  output logic                push,
  output oflt_pkg::vtx_t      push_vtx
);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_FACE  = 2'd1;
  localparam logic [1:0] MODE_SKIP  = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam int W = oflt_pkg::IdxW;

  logic [1:0]   mode_r, mode_nxt;
  logic [1:0]   slot_r, slot_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic         neg_r, neg_nxt;
  logic         seen_r, seen_nxt;
  logic [1:0]   ord_r, ord_nxt;
  logic         open_r, open_nxt;
  logic [W-1:0] cur_r [3];
  logic [W-1:0] cur_nxt [3];

  logic [W-1:0] fld_val;
  logic [W-1:0] fin [3];
  logic [7:0]   dig;
  logic         is_digit;
  logic         finish;

  assign fld_val  = neg_r ? (W'(0) - acc_r) : acc_r;
  assign dig      = byte_in - CH_ZERO;
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = (slot_r == 2'(i)) ? fld_val : cur_r[i];
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    slot_nxt = slot_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    seen_nxt = seen_r;
    ord_nxt  = ord_r;
    open_nxt = open_r;
    for (int i = 0; i < 3; i++) begin
      cur_nxt[i] = cur_r[i];
    end
    finish = 1'b0;

    if (byte_take) begin
      if (byte_in == CH_NL) begin
        finish   = (mode_r == MODE_FACE) && open_r;
        mode_nxt = MODE_START;
        slot_nxt = 2'd0;
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
        seen_nxt = 1'b0;
        ord_nxt  = oflt_pkg::ORD_FIRST;
        open_nxt = 1'b0;
        for (int i = 0; i < 3; i++) begin
          cur_nxt[i] = '0;
        end
      end else begin
        unique case (mode_r)
          MODE_START: begin
            mode_nxt = (byte_in == CH_F) ? MODE_FACE : MODE_SKIP;
          end
          MODE_FACE: begin
            if (byte_in == CH_SPACE) begin
              if (open_r) begin
                finish   = 1'b1;
                slot_nxt = 2'd0;
                acc_nxt  = '0;
                neg_nxt  = 1'b0;
                seen_nxt = 1'b0;
                open_nxt = 1'b0;
                ord_nxt  = (ord_r == oflt_pkg::ORD_FIRST) ? oflt_pkg::ORD_SECOND
                                                          : oflt_pkg::ORD_LATER;
                for (int i = 0; i < 3; i++) begin
                  cur_nxt[i] = '0;
                end
              end
            end else if (is_digit) begin
              acc_nxt  = (acc_r << 3) + (acc_r << 1) + W'(dig[3:0]);
              seen_nxt = 1'b1;
              open_nxt = 1'b1;
            end else if (byte_in == CH_MINUS || byte_in == CH_PLUS) begin
              if (!seen_r && byte_in == CH_MINUS) begin
                neg_nxt = 1'b1;
              end
              open_nxt = 1'b1;
            end else if (byte_in == CH_SLASH) begin
              if (slot_r < 2'd2) begin
                cur_nxt[slot_r] = fld_val;
                acc_nxt  = '0;
                neg_nxt  = 1'b0;
                seen_nxt = 1'b0;
                slot_nxt = slot_r + 2'd1;
              end
              open_nxt = 1'b1;
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
    end
  end

  assign push         = finish;
  assign push_vtx.pos = fin[0];
  assign push_vtx.tex = fin[1];
  assign push_vtx.nrm = fin[2];
  assign push_vtx.ord = ord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      slot_r <= 2'd0;
      acc_r  <= '0;
      neg_r  <= 1'b0;
      seen_r <= 1'b0;
      ord_r  <= oflt_pkg::ORD_FIRST;
      open_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= '0;
      end
    end else begin
      mode_r <= mode_nxt;
      slot_r <= slot_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      seen_r <= seen_nxt;
      ord_r  <= ord_nxt;
      open_r <= open_nxt;
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= cur_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/oflt_vtx_queue.sv -----
// Small FIFO of finished vertices between the parser and the triangle stage.
module oflt_vtx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  oflt_pkg::vtx_t      push_vtx,
  input  logic                pop,
  output oflt_pkg::vtx_t      head,
  output oflt_pkg::q_stat_t   stat
);

  localparam int AW = oflt_pkg::QAddrW;

  oflt_pkg::vtx_t mem [oflt_pkg::QDepth];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (count_r == (AW+1)'(oflt_pkg::QDepth));
  assign stat.empty = (count_r == '0);

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push) else $error("vertex pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop) else $error("vertex popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(oflt_pkg::QDepth)) else $error("queue count beyond depth");
`endif

endmodule

// ----- rtl/oflt_back.sv -----
// Triangle stage: tracks first and previous vertex, builds fan triangles into the output register.
module oflt_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  oflt_pkg::vtx_t            head,
  input  oflt_pkg::q_stat_t         stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [23:0]               out_tri_index,
  output logic signed [31:0]        out_pos_a,
  output logic signed [31:0]        out_pos_b,
  output logic signed [31:0]        out_pos_c,
  output logic signed [31:0]        out_tex_a,
  output logic signed [31:0]        out_tex_b,
  output logic signed [31:0]        out_tex_c,
  output logic signed [31:0]        out_nrm_a,
  output logic signed [31:0]        out_nrm_b,
  output logic signed [31:0]        out_nrm_c
);

  localparam int W = oflt_pkg::IdxW;

  logic [W-1:0]                      cur [3];
  logic [W-1:0]                      first_r [3];
  logic [W-1:0]                      prev_r [3];
  logic [W-1:0]                      oa_r [3];
  logic [W-1:0]                      ob_r [3];
  logic [W-1:0]                      oc_r [3];
  logic [oflt_pkg::TriIndexBits-1:0] cnt_r;
  logic [23:0]                       tri_r;
  logic                              out_valid_r, out_valid_nxt;
  logic                              emit;

  assign cur[0] = head.pos - W'(1);
  assign cur[1] = head.tex - W'(1);
  assign cur[2] = head.nrm - W'(1);

  assign pop  = !stat.empty && !(out_valid_r && out_stall);
  assign emit = pop && (head.ord == oflt_pkg::ORD_LATER);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= cur[i];
      end
      if (head.ord == oflt_pkg::ORD_FIRST) begin
        for (int i = 0; i < 3; i++) begin
          first_r[i] <= cur[i];
        end
      end
    end
    if (emit) begin
      tri_r <= 24'(cnt_r);
      for (int i = 0; i < 3; i++) begin
        oa_r[i] <= first_r[i];
        ob_r[i] <= prev_r[i];
        oc_r[i] <= cur[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tri_index = tri_r;
  assign out_pos_a     = oa_r[0];
  assign out_pos_b     = ob_r[0];
  assign out_pos_c     = oc_r[0];
  assign out_tex_a     = oa_r[1];
  assign out_tex_b     = ob_r[1];
  assign out_tex_c     = oc_r[1];
  assign out_nrm_a     = oa_r[2];
  assign out_nrm_b     = ob_r[2];
  assign out_nrm_c     = oc_r[2];

`ifndef SYNTHESIS
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r) else $error("triangle not presented after emit");
  a_hold_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !pop) else $error("vertex taken while output held");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> cnt_r == $past(cnt_r) + 1'b1) else $error("triangle counter did not advance");
  a_cnt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !emit |=> cnt_r == $past(cnt_r)) else $error("triangle counter moved without emit");
`endif

endmodule

// ----- rtl/obj_face_line_triangulator.sv -----
// Top level of the OBJ face line parser with fan triangulation.
// Usage:
//   Input channel (in_valid, in_stall, in_char_in) takes one byte of OBJ text
//   per item. Lines starting with 'f' are parsed as faces; others are skipped.
//   Output channel (out_valid, out_stall, out_* fields) gives one triangle per
//   item: slot number plus position, texture and normal indices (zero based,
//   -1 when a field is absent) of the fan's first, previous and current vertex.
// Throughput: one byte per cycle while in_stall is low. The parser, a
//   four-entry vertex queue and the triangle register form three decoupled
//   steps, so bytes keep flowing while a finished triangle waits.
// Path: a vertex's closing space or newline pushes it into the queue; the
//   triangle stage pops it and, for third and later vertices, loads out_*.
// Stall: while out_stall holds a triangle, vertices collect in the queue; when
//   it fills, in_stall rises until the triangle is taken.
// Reset: rst_n low for one cycle clears all control state and the triangle
//   counter; no clearing pass follows, the block takes bytes right away.
module obj_face_line_triangulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_tri_index,
  output logic signed [31:0] out_pos_a,
  output logic signed [31:0] out_pos_b,
  output logic signed [31:0] out_pos_c,
  output logic signed [31:0] out_tex_a,
  output logic signed [31:0] out_tex_b,
  output logic signed [31:0] out_tex_c,
  output logic signed [31:0] out_nrm_a,
  output logic signed [31:0] out_nrm_b,
  output logic signed [31:0] out_nrm_c
);

  oflt_pkg::vtx_t    push_vtx;
  oflt_pkg::vtx_t    head;
  oflt_pkg::q_stat_t stat;
  logic              push;
  logic              pop;
  logic              byte_take;

  assign in_stall  = stat.full;
  assign byte_take = in_valid && !stat.full;

  oflt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .byte_in   (in_char_in),
    .push      (push),
    .push_vtx  (push_vtx)
  );

  oflt_vtx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_vtx (push_vtx),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  oflt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tri_index (out_tri_index),
    .out_pos_a     (out_pos_a),
    .out_pos_b     (out_pos_b),
    .out_pos_c     (out_pos_c),
    .out_tex_a     (out_tex_a),
    .out_tex_b     (out_tex_b),
    .out_tex_c     (out_tex_c),
    .out_nrm_a     (out_nrm_a),
    .out_nrm_b     (out_nrm_b),
    .out_nrm_c     (out_nrm_c)
  );

endmodule

// ----- test/obj_face_line_triangulator_tb.sv -----
// Testbench for obj_face_line_triangulator: OBJ text in, fan triangles checked in order.
module obj_face_line_triangulator_tb;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int POS_FIELD = 0;
  localparam int TEX_FIELD = 1;
  localparam int NRM_FIELD = 2;

  typedef enum logic [1:0] {AT_START, IN_FACE, SKIPPING} line_mode_t;

  typedef struct {
    logic [23:0] slot;
    logic [31:0] pos[3];
    logic [31:0] tex[3];
    logic [31:0] nrm[3];
  } triangle_t;

  class fan_triangle_tracker;
    line_mode_t                          mode;
    int                                  field;
    logic [31:0]                         acc;
    bit                                  neg;
    bit                                  seen;
    bit                                  open;
    logic [1:0]                          ordinal;
    logic [31:0]                         cur_raw[3];
    logic [31:0]                         first_idx[3];
    logic [31:0]                         prev_idx[3];
    logic [oflt_pkg::TriIndexBits-1:0]   tri_count;
    triangle_t                           pending_tris[$];
    int                                  errors;

    function new();
      mode      = AT_START;
      field     = POS_FIELD;
      acc       = '0;
      neg       = 0;
      seen      = 0;
      open      = 0;
      ordinal   = oflt_pkg::ORD_FIRST;
      cur_raw   = '{default: '0};
      first_idx = '{default: '0};
      prev_idx  = '{default: '0};
      tri_count = '0;
      errors    = 0;
    endfunction

    function void commit_field();
      cur_raw[field] = neg ? (32'd0 - acc) : acc;
      acc  = '0;
      neg  = 0;
      seen = 0;
    endfunction

    function void finish_vertex();
      logic [31:0] idx[3];
      triangle_t   t;
      commit_field();
      for (int i = 0; i < 3; i++) idx[i] = cur_raw[i] - 32'd1;
      if (ordinal == oflt_pkg::ORD_FIRST) first_idx = idx;
      if (ordinal == oflt_pkg::ORD_LATER) begin
        t.slot = 24'(tri_count);
        t.pos  = '{first_idx[POS_FIELD], prev_idx[POS_FIELD], idx[POS_FIELD]};
        t.tex  = '{first_idx[TEX_FIELD], prev_idx[TEX_FIELD], idx[TEX_FIELD]};
        t.nrm  = '{first_idx[NRM_FIELD], prev_idx[NRM_FIELD], idx[NRM_FIELD]};
        pending_tris.push_back(t);
        tri_count++;
      end
      prev_idx = idx;
      if (ordinal != oflt_pkg::ORD_LATER) ordinal++;
      cur_raw = '{default: '0};
      field   = POS_FIELD;
      open    = 0;
    endfunction

    function void note_byte(logic [7:0] c);
      if (c == CH_NL) begin
        if (mode == IN_FACE && open) finish_vertex();
        mode    = AT_START;
        field   = POS_FIELD;
        acc     = '0;
        neg     = 0;
        seen    = 0;
        ordinal = oflt_pkg::ORD_FIRST;
        cur_raw = '{default: '0};
        open    = 0;
      end else if (mode == AT_START) begin
        mode = (c == CH_F) ? IN_FACE : SKIPPING;
      end else if (mode == IN_FACE) begin
        if (c == CH_SP) begin
          if (open) finish_vertex();
        end else if (c >= CH_0 && c <= CH_9) begin
          acc  = acc * 32'd10 + 32'(c - CH_0);
          seen = 1;
          open = 1;
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          if (!seen && c == CH_MINUS) neg = 1;
          open = 1;
        end else if (c == CH_SLASH) begin
          if (field != NRM_FIELD) begin
            commit_field();
            field++;
          end
          open = 1;
        end
      end
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)", name,
               $signed(exp_v), exp_v, $signed(act_v), act_v);
        errors++;
      end
    endfunction

    function void check_triangle(triangle_t got);
      triangle_t exp_t;
      string     sfx[3];
      sfx = '{"a", "b", "c"};
      if (pending_tris.size() == 0) begin
        $error("unexpected triangle with tri_index %0d", got.slot);
        errors++;
        return;
      end
      exp_t = pending_tris.pop_front();
      compare("tri_index", 32'(exp_t.slot), 32'(got.slot));
      for (int i = 0; i < 3; i++) begin
        compare({"pos_", sfx[i]}, exp_t.pos[i], got.pos[i]);
        compare({"tex_", sfx[i]}, exp_t.tex[i], got.tex[i]);
        compare({"nrm_", sfx[i]}, exp_t.nrm[i], got.nrm[i]);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_char_in;
  logic               out_valid;
  logic               out_stall;
  logic [23:0]        out_tri_index;
  logic signed [31:0] out_pos_a, out_pos_b, out_pos_c;
  logic signed [31:0] out_tex_a, out_tex_b, out_tex_c;
  logic signed [31:0] out_nrm_a, out_nrm_b, out_nrm_c;

  fan_triangle_tracker tracker = new();
  logic [7:0]          text_q[$];
  bit                  quiet;

  obj_face_line_triangulator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_in(in_char_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tri_index(out_tri_index),
    .out_pos_a(out_pos_a),
    .out_pos_b(out_pos_b),
    .out_pos_c(out_pos_c),
    .out_tex_a(out_tex_a),
    .out_tex_b(out_tex_b),
    .out_tex_c(out_tex_c),
    .out_nrm_a(out_nrm_a),
    .out_nrm_b(out_nrm_b),
    .out_nrm_c(out_nrm_c)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_byte(in_char_in);
  end

  always @(posedge clk) begin
    triangle_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.slot = out_tri_index;
      got.pos  = '{out_pos_a, out_pos_b, out_pos_c};
      got.tex  = '{out_tex_a, out_tex_b, out_tex_c};
      got.nrm  = '{out_nrm_a, out_nrm_b, out_nrm_c};
      tracker.check_triangle(got);
    end
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_number();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) push_text("-");
    else if (r == 1) push_text("+");
    else if (r == 2) return;
    r = $urandom_range(0, 19);
    if (r < 15) push_text($sformatf("%0d", $urandom_range(0, 30)));
    else if (r < 17) push_text($sformatf("%0d", $urandom_range(0, 99999)));
    else if (r < 19) push_text($sformatf("%0d", $urandom()));
    else push_text($sformatf("%0d%0d", $urandom(), $urandom_range(0, 9)));
    r = $urandom_range(0, 24);
    if (r == 0) text_q.push_back(CH_MINUS);
    else if (r == 1) text_q.push_back(CH_CR);
    else if (r == 2) text_q.push_back(CH_TAB);
  endfunction

  function automatic void push_face_line();
    int nv;
    nv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    text_q.push_back(CH_F);
    for (int v = 0; v < nv; v++) begin
      repeat ($urandom_range(v == 0 ? 0 : 1, 2)) text_q.push_back(CH_SP);
      case ($urandom_range(0, 5))
        0: push_number();
        1: begin push_number(); push_text("/"); push_number(); end
        2: begin push_number(); push_text("/"); push_number(); push_text("/"); push_number(); end
        3: begin push_number(); push_text("//"); push_number(); end
        4: begin
          push_number(); push_text("/"); push_number(); push_text("/");
          push_number(); push_text("/"); push_number();
        end
        default: push_text($urandom_range(0, 1) ? "-" : "/");
      endcase
    end
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_SP);
    if ($urandom_range(0, 5) == 0) text_q.push_back(CH_CR);
    text_q.push_back(CH_NL);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int n;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int r;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_char_in = '0;
    quiet      = 0;

    push_text("f 1//2 -/  3/4/5/6\t 4294967297 0-\n");
    push_text("xf 1 2 3\n\n");
    push_text("f 5 /\n");
    push_text("f -2147483647/0/2147483648 +/ 00\377\000 9\n");
    while (text_q.size() < 1150) begin
      r = $urandom_range(0, 9);
      if (r < 7) push_face_line();
      else if (r < 9) begin
        text_q.push_back(CH_F);
        repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(CH_NL);
      end else begin
        repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(CH_NL);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (text_q[i]) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_byte(text_q[i]);
    end
    in_valid <= 1'b0;
    quiet = 0;
    @(posedge clk);
    while (tracker.pending_tris.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_tris.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- obj_face_line_triangulator.f -----
rtl/oflt_pkg.sv
rtl/oflt_front.sv
rtl/oflt_vtx_queue.sv
rtl/oflt_back.sv
rtl/obj_face_line_triangulator.sv
test/obj_face_line_triangulator_tb.sv
